[sv/mnst_pkg.sv]
// Shared types and constants of the MIDI note sustain tracker.
package mnst_pkg;

  // Default number of tracked notes
  localparam int NoteCountDefault = 128;

  // Field widths fixed by the MIDI event format
  localparam int ActionW = 3;
  localparam int NoteW   = 7;
  localparam int ValueW  = 7;
  localparam int KindW   = 2;
  localparam int MaskW   = 64;

  // Event codes of an incoming request
  typedef enum logic [ActionW-1:0] {
    ACT_NOTE_ON      = 3'd0,
    ACT_NOTE_OFF     = 3'd1,
    ACT_SUSTAIN_ON   = 3'd2,
    ACT_SUSTAIN_OFF  = 3'd3,
    ACT_PRESSURE     = 3'd4
  } mnst_action_e;

  // Result kinds
  typedef enum logic [KindW-1:0] {
    KIND_START        = 2'd0,
    KIND_RELEASE_ONE  = 2'd1,
    KIND_RELEASE_MASK = 2'd2,
    KIND_PRESSURE     = 2'd3
  } mnst_kind_e;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } mnst_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture the request fields
    logic exec;  // update the note maps and build the result
  } mnst_cmd_t;

endpackage

[sv/mnst_ctrl.sv]
// Controller state machine of the MIDI note sustain tracker.
module mnst_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output mnst_pkg::mnst_cmd_t cmd_o
);
  import mnst_pkg::*;

  mnst_state_e state_q, state_d;

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: each accepted request passes through the execute state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs: load on accept, execute in the busy cycle
  always_comb begin
    busy_o     = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = start_i;
      end
      ST_EXEC: begin
        busy_o     = 1'b1;
        cmd_o.exec = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

endmodule

[sv/mnst_datapath.sv]
// Datapath of the MIDI note sustain tracker: note maps, pedal flag and result registers.
module mnst_datapath #(
  parameter int NOTE_COUNT = mnst_pkg::NoteCountDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mnst_pkg::mnst_cmd_t          cmd_i,
  input  logic [mnst_pkg::ActionW-1:0] action_i,
  input  logic [mnst_pkg::NoteW-1:0]   note_i,
  input  logic [mnst_pkg::ValueW-1:0]  velocity_i,
  input  logic [mnst_pkg::ValueW-1:0]  pressure_i,
  output logic                         done_o,
  output logic [mnst_pkg::KindW-1:0]   kind_o,
  output logic [mnst_pkg::NoteW-1:0]   note_number_o,
  output logic [mnst_pkg::ValueW-1:0]  start_velocity_o,
  output logic                         retrigger_o,
  output logic [mnst_pkg::MaskW-1:0]   release_mask_low_o,
  output logic [mnst_pkg::MaskW-1:0]   release_mask_high_o,
  output logic [mnst_pkg::ValueW-1:0]  pressure_value_o
);
  import mnst_pkg::*;

  localparam int IdxW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;

  // Captured request
  logic [ActionW-1:0] action_q;
  logic [NoteW-1:0]   note_q;
  logic [ValueW-1:0]  vel_q;
  logic [ValueW-1:0]  pres_q;

  // Note state
  logic [NOTE_COUNT-1:0] held_q, held_d;
  logic [NOTE_COUNT-1:0] sus_q, sus_d;
  logic [NOTE_COUNT-1:0] snd_q, snd_d;
  logic                  pedal_q, pedal_d;

  // Result
  logic                 done_q, done_d;
  logic [KindW-1:0]     kind_q, kind_d;
  logic [NoteW-1:0]     nnum_q, nnum_d;
  logic [ValueW-1:0]    svel_q, svel_d;
  logic                 retrig_q, retrig_d;
  logic [2*MaskW-1:0]   mask_q, mask_d;
  logic [ValueW-1:0]    pval_q, pval_d;

  logic                  in_range;
  logic [IdxW-1:0]       idx;
  logic [NOTE_COUNT-1:0] onehot;
  logic [NOTE_COUNT-1:0] rel_mask;

  assign in_range = ({1'b0, note_q} < (NoteW + 1)'(NOTE_COUNT));
  assign idx      = note_q[IdxW-1:0];
  assign onehot   = NOTE_COUNT'(1) << idx;
  assign rel_mask = sus_q & ~held_q & snd_q;

  // Capture the request fields on accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      note_q   <= note_i;
      vel_q    <= velocity_i;
      pres_q   <= pressure_i;
    end
  end

  // Apply one event to the maps and build its result
  always_comb begin
    held_d   = held_q;
    sus_d    = sus_q;
    snd_d    = snd_q;
    pedal_d  = pedal_q;
    done_d   = 1'b0;
    kind_d   = kind_q;
    nnum_d   = nnum_q;
    svel_d   = svel_q;
    retrig_d = retrig_q;
    mask_d   = mask_q;
    pval_d   = pval_q;
    if (cmd_i.exec) begin
      kind_d   = KIND_START;
      nnum_d   = '0;
      svel_d   = '0;
      retrig_d = 1'b0;
      mask_d   = '0;
      pval_d   = '0;
      case (action_q)
        ACT_NOTE_ON: begin
          if (in_range && !held_q[idx]) begin
            held_d = held_q | onehot;
            if (pedal_q) sus_d = sus_q | onehot;
            snd_d    = snd_q | onehot;
            retrig_d = snd_q[idx];
            kind_d   = KIND_START;
            nnum_d   = note_q;
            svel_d   = vel_q;
            done_d   = 1'b1;
          end
        end
        ACT_NOTE_OFF: begin
          if (in_range && held_q[idx]) begin
            held_d = held_q & ~onehot;
            if (!pedal_q) begin
              snd_d  = snd_q & ~onehot;
              kind_d = KIND_RELEASE_ONE;
              nnum_d = note_q;
              done_d = 1'b1;
            end
          end
        end
        ACT_SUSTAIN_ON: begin
          pedal_d = 1'b1;
          sus_d   = sus_q | held_q;
        end
        ACT_SUSTAIN_OFF: begin
          pedal_d = 1'b0;
          snd_d   = snd_q & ~rel_mask;
          sus_d   = '0;
          kind_d  = KIND_RELEASE_MASK;
          mask_d  = (2 * MaskW)'(rel_mask);
          done_d  = 1'b1;
        end
        ACT_PRESSURE: begin
          kind_d = KIND_PRESSURE;
          pval_d = pres_q;
          done_d = 1'b1;
        end
        default: begin
          done_d = 1'b0;
        end
      endcase
    end
  end

  // Hold note state and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      sus_q   <= '0;
      snd_q   <= '0;
      pedal_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      held_q  <= held_d;
      sus_q   <= sus_d;
      snd_q   <= snd_d;
      pedal_q <= pedal_d;
      done_q  <= done_d;
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    nnum_q   <= nnum_d;
    svel_q   <= svel_d;
    retrig_q <= retrig_d;
    mask_q   <= mask_d;
    pval_q   <= pval_d;
  end

  assign done_o              = done_q;
  assign kind_o              = kind_q;
  assign note_number_o       = nnum_q;
  assign start_velocity_o    = svel_q;
  assign retrigger_o         = retrig_q;
  assign release_mask_low_o  = mask_q[MaskW-1:0];
  assign release_mask_high_o = mask_q[2*MaskW-1:MaskW];
  assign pressure_value_o    = pval_q;

endmodule

[sv/midi_note_sustain_tracker_unit.sv]
// Top level of the MIDI note sustain tracker: controller plus datapath.
// Requests are registered on accept; ST_EXEC updates the maps and registers the result strobe.
// busy_o is high for the single execute cycle; no request is accepted while it is high.
// No-result requests (held note on, sustain on, unknown code and others) still go through EXEC.
// The receiver cannot stall: done_o is high for exactly one cycle; the result ports then hold.
// Reset (rst_ni low, asynchronous) clears all note maps, the pedal flag and the controller.
module midi_note_sustain_tracker_unit #(
  parameter int NOTE_COUNT = mnst_pkg::NoteCountDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mnst_pkg::ActionW-1:0] action_i,
  input  logic [mnst_pkg::NoteW-1:0]   note_i,
  input  logic [mnst_pkg::ValueW-1:0]  velocity_i,
  input  logic [mnst_pkg::ValueW-1:0]  pressure_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [mnst_pkg::KindW-1:0]   kind_o,
  output logic [mnst_pkg::NoteW-1:0]   note_number_o,
  output logic [mnst_pkg::ValueW-1:0]  start_velocity_o,
  output logic                         retrigger_o,
  output logic [mnst_pkg::MaskW-1:0]   release_mask_low_o,
  output logic [mnst_pkg::MaskW-1:0]   release_mask_high_o,
  output logic [mnst_pkg::ValueW-1:0]  pressure_value_o
);
  import mnst_pkg::*;

  mnst_cmd_t cmd;

  // Sequence each request
  mnst_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  // Track notes and build results
  mnst_datapath #(
    .NOTE_COUNT (NOTE_COUNT)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .action_i            (action_i),
    .note_i              (note_i),
    .velocity_i          (velocity_i),
    .pressure_i          (pressure_i),
    .done_o              (done_o),
    .kind_o              (kind_o),
    .note_number_o       (note_number_o),
    .start_velocity_o    (start_velocity_o),
    .retrigger_o         (retrigger_o),
    .release_mask_low_o  (release_mask_low_o),
    .release_mask_high_o (release_mask_high_o),
    .pressure_value_o    (pressure_value_o)
  );

endmodule

[sv/mnst_checker.sv]
// Port-level checks of the MIDI note sustain tracker and their bind.
module mnst_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic [mnst_pkg::ValueW-1:0]  pressure_i,
  input logic                         busy_o,
  input logic                         done_o,
  input logic [mnst_pkg::KindW-1:0]   kind_o,
  input logic [mnst_pkg::ValueW-1:0]  start_velocity_o,
  input logic                         retrigger_o,
  input logic [mnst_pkg::ValueW-1:0]  pressure_value_o
);
  import mnst_pkg::*;

  // An accepted request makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after accepted request");

  // Busy lasts one cycle
  a_busy_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("busy held longer than one cycle");

  // A result follows the execute cycle
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result strobe without preceding busy cycle");

  // Start-only fields stay zero on other kinds
  a_start_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && kind_o != KIND_START |-> !retrigger_o && start_velocity_o == '0)
    else $error("start fields set on non-start result");

  // Pressure is forwarded from its request
  a_pressure_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && kind_o == KIND_PRESSURE |-> pressure_value_o == $past(pressure_i, 2))
    else $error("pressure value does not match its request");

endmodule

bind midi_note_sustain_tracker_unit mnst_checker u_mnst_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .pressure_i       (pressure_i),
  .busy_o           (busy_o),
  .done_o           (done_o),
  .kind_o           (kind_o),
  .start_velocity_o (start_velocity_o),
  .retrigger_o      (retrigger_o),
  .pressure_value_o (pressure_value_o)
);

[verif/midi_note_sustain_tracker_checker.sv]
// Checker of the MIDI note sustain tracker: predicts every result and compares it.
module midi_note_sustain_tracker_checker
  import mnst_pkg::*;
#(
  parameter int NOTE_COUNT = NoteCountDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [ActionW-1:0] action_i,
  input  logic [NoteW-1:0]   note_i,
  input  logic [ValueW-1:0]  velocity_i,
  input  logic [ValueW-1:0]  pressure_i,
  input  logic               done_i,
  input  logic [KindW-1:0]   kind_i,
  input  logic [NoteW-1:0]   note_number_i,
  input  logic [ValueW-1:0]  start_velocity_i,
  input  logic               retrigger_i,
  input  logic [MaskW-1:0]   release_mask_low_i,
  input  logic [MaskW-1:0]   release_mask_high_i,
  input  logic [ValueW-1:0]  pressure_value_i,
  output int                 err_count_o,
  output int                 pending_o
);

  typedef struct packed {
    mnst_kind_e        kind;
    logic [NoteW-1:0]  note;
    logic [ValueW-1:0] velocity;
    logic              retrigger;
    logic [MaskW-1:0]  mask_low;
    logic [MaskW-1:0]  mask_high;
    logic [ValueW-1:0] pressure;
  } voice_result_t;

  // Shadow copy of the note maps and the pedal
  logic [127:0]  held_notes;
  logic [127:0]  pedal_notes;
  logic [127:0]  ringing_notes;
  logic          pedal;
  voice_result_t expected_results[$];

  // Apply one MIDI event to the shadow maps and queue the result it causes
  task automatic track_event(input logic [ActionW-1:0] act, input logic [NoteW-1:0] nt,
                             input logic [ValueW-1:0] vel, input logic [ValueW-1:0] pres);
    voice_result_t res;
    logic [127:0]  freed;
    res = '0;
    case (act)
      ACT_NOTE_ON: begin
        if (int'(nt) < NOTE_COUNT && !held_notes[nt]) begin
          held_notes[nt] = 1'b1;
          if (pedal) pedal_notes[nt] = 1'b1;
          res.kind      = KIND_START;
          res.note      = nt;
          res.velocity  = vel;
          res.retrigger = ringing_notes[nt];
          ringing_notes[nt] = 1'b1;
          expected_results.push_back(res);
        end
      end
      ACT_NOTE_OFF: begin
        if (int'(nt) < NOTE_COUNT && held_notes[nt]) begin
          held_notes[nt] = 1'b0;
          // keep the voice ringing while the pedal is down
          if (!pedal) begin
            ringing_notes[nt] = 1'b0;
            res.kind = KIND_RELEASE_ONE;
            res.note = nt;
            expected_results.push_back(res);
          end
        end
      end
      ACT_SUSTAIN_ON: begin
        pedal       = 1'b1;
        pedal_notes = pedal_notes | held_notes;
      end
      ACT_SUSTAIN_OFF: begin
        freed         = pedal_notes & ~held_notes & ringing_notes;
        pedal         = 1'b0;
        ringing_notes = ringing_notes & ~freed;
        pedal_notes   = '0;
        res.kind      = KIND_RELEASE_MASK;
        res.mask_low  = freed[63:0];
        res.mask_high = freed[127:64];
        expected_results.push_back(res);
      end
      ACT_PRESSURE: begin
        res.kind     = KIND_PRESSURE;
        res.pressure = pres;
        expected_results.push_back(res);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [MaskW-1:0] exp_val,
                             input logic [MaskW-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
      err_count_o++;
    end
  endtask

  // Compare the result of this edge first, then record the request taken at it
  always @(posedge clk_i or negedge rst_ni) begin
    voice_result_t exp_res;
    if (!rst_ni) begin
      held_notes    = '0;
      pedal_notes   = '0;
      ringing_notes = '0;
      pedal         = 1'b0;
      err_count_o   = 0;
      expected_results.delete();
    end else begin
      if (done_i) begin
        if (expected_results.size() == 0) begin
          $error("result: expected none, actual kind %0d", kind_i);
          err_count_o++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("kind", MaskW'(exp_res.kind), MaskW'(kind_i));
          check_field("note_number", MaskW'(exp_res.note), MaskW'(note_number_i));
          check_field("start_velocity", MaskW'(exp_res.velocity), MaskW'(start_velocity_i));
          check_field("retrigger", MaskW'(exp_res.retrigger), MaskW'(retrigger_i));
          check_field("release_mask_low", exp_res.mask_low, release_mask_low_i);
          check_field("release_mask_high", exp_res.mask_high, release_mask_high_i);
          check_field("pressure_value", MaskW'(exp_res.pressure), MaskW'(pressure_value_i));
        end
      end
      if (start_i && !busy_i) begin
        track_event(action_i, note_i, velocity_i, pressure_i);
      end
    end
    pending_o = expected_results.size();
  end

endmodule

[verif/midi_note_sustain_tracker_unit_tb.sv]
// Testbench top of the MIDI note sustain tracker: stimulus, watchdog and verdict.
module midi_note_sustain_tracker_unit_tb;
  import mnst_pkg::*;

  localparam int NOTE_COUNT  = 128;
  localparam int QuietLimit  = 2000;
  localparam int ItemsPerRun = 425;
  localparam int DrainCycles = 4;

  logic              clk_i    = 1'b0;
  logic              rst_ni   = 1'b0;
  logic              start_i  = 1'b0;
  logic [ActionW-1:0] action_i = '0;
  logic [NoteW-1:0]  note_i   = '0;
  logic [ValueW-1:0] velocity_i = '0;
  logic [ValueW-1:0] pressure_i = '0;
  logic              busy_o;
  logic              done_o;
  logic [KindW-1:0]  kind_o;
  logic [NoteW-1:0]  note_number_o;
  logic [ValueW-1:0] start_velocity_o;
  logic              retrigger_o;
  logic [MaskW-1:0]  release_mask_low_o;
  logic [MaskW-1:0]  release_mask_high_o;
  logic [ValueW-1:0] pressure_value_o;
  int                err_count;
  int                pending;
  int                idle_pct = 0;

  midi_note_sustain_tracker_unit #(.NOTE_COUNT(NOTE_COUNT)) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .action_i           (action_i),
    .note_i             (note_i),
    .velocity_i         (velocity_i),
    .pressure_i         (pressure_i),
    .busy_o             (busy_o),
    .done_o             (done_o),
    .kind_o             (kind_o),
    .note_number_o      (note_number_o),
    .start_velocity_o   (start_velocity_o),
    .retrigger_o        (retrigger_o),
    .release_mask_low_o (release_mask_low_o),
    .release_mask_high_o(release_mask_high_o),
    .pressure_value_o   (pressure_value_o)
  );

  midi_note_sustain_tracker_checker #(.NOTE_COUNT(NOTE_COUNT)) checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_i             (busy_o),
    .action_i           (action_i),
    .note_i             (note_i),
    .velocity_i         (velocity_i),
    .pressure_i         (pressure_i),
    .done_i             (done_o),
    .kind_i             (kind_o),
    .note_number_i      (note_number_o),
    .start_velocity_i   (start_velocity_o),
    .retrigger_i        (retrigger_o),
    .release_mask_low_i (release_mask_low_o),
    .release_mask_high_i(release_mask_high_o),
    .pressure_value_i   (pressure_value_o),
    .err_count_o        (err_count),
    .pending_o          (pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Hold off at random, then present one request until it is taken
  task automatic send_request(input logic [ActionW-1:0] act, input logic [NoteW-1:0] nt,
                              input logic [ValueW-1:0] vel, input logic [ValueW-1:0] pres);
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    action_i   <= act;
    note_i     <= nt;
    velocity_i <= vel;
    pressure_i <= pres;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Mostly note traffic around a small window of keys, with pedal moves in between
  task automatic random_request(input int base, input int span, output bit counted);
    int                 pick;
    logic [ActionW-1:0] act;
    logic [NoteW-1:0]   nt;
    pick = $urandom_range(0, 99);
    if (pick < 38)      act = ACT_NOTE_ON;
    else if (pick < 70) act = ACT_NOTE_OFF;
    else if (pick < 79) act = ACT_SUSTAIN_ON;
    else if (pick < 88) act = ACT_SUSTAIN_OFF;
    else if (pick < 97) act = ACT_PRESSURE;
    else                act = ActionW'($urandom_range(int'(ACT_PRESSURE) + 1, 7));
    nt = NoteW'((base + $urandom_range(0, span - 1)) % 128);
    counted = (act <= ACT_PRESSURE);
    send_request(act, nt, ValueW'($urandom), ValueW'($urandom));
  endtask

  // Stop the run when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || done_o) quiet = 0;
      else quiet++;
    end
    $display("midi_note_sustain_tracker_unit_tb: errors");
    $finish;
  end

  initial begin
    int idle_tab[4];
    int sent;
    int base;
    int span;
    bit counted;
    idle_tab = '{0, 73, 0, 11};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every event, retrigger, pedal catch and release
    send_request(ACT_PRESSURE, 7'd0, 7'd0, 7'd0);
    send_request(ACT_PRESSURE, 7'd127, 7'd127, 7'd127);
    send_request(ACT_NOTE_ON, 7'd0, 7'd127, 7'd0);
    send_request(ACT_NOTE_ON, 7'd127, 7'd0, 7'd127);
    send_request(ACT_NOTE_ON, 7'd0, 7'd55, 7'd0);
    send_request(ACT_NOTE_OFF, 7'd0, 7'd0, 7'd0);
    send_request(ACT_NOTE_OFF, 7'd0, 7'd127, 7'd127);
    send_request(ACT_SUSTAIN_OFF, 7'd0, 7'd0, 7'd0);
    send_request(ACT_NOTE_ON, 7'd64, 7'd1, 7'd0);
    send_request(ACT_SUSTAIN_ON, 7'd0, 7'd0, 7'd0);
    send_request(ACT_NOTE_OFF, 7'd127, 7'd0, 7'd0);
    send_request(ACT_NOTE_ON, 7'd127, 7'd100, 7'd0);
    send_request(ACT_NOTE_OFF, 7'd127, 7'd0, 7'd0);
    send_request(ACT_NOTE_ON, 7'd5, 7'd64, 7'd0);
    send_request(ACT_NOTE_OFF, 7'd5, 7'd0, 7'd0);
    send_request(ACT_SUSTAIN_ON, 7'd127, 7'd127, 7'd127);
    send_request(ACT_SUSTAIN_OFF, 7'd0, 7'd0, 7'd0);
    send_request(ACT_NOTE_OFF, 7'd64, 7'd0, 7'd0);
    for (int c = int'(ACT_PRESSURE) + 1; c < 8; c++) begin
      send_request(ActionW'(c), 7'd127, 7'd127, 7'd127);
    end
    send_request(ACT_NOTE_ON, 7'd5, 7'd3, 7'd0);
    send_request(ACT_SUSTAIN_OFF, 7'd0, 7'd0, 7'd0);
    send_request(ACT_NOTE_OFF, 7'd5, 7'd0, 7'd0);

    // Random: one run per idling pattern, key window redrawn every burst
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_tab[ph];
      sent = 0;
      base = 0;
      span = 8;
      while (sent < ItemsPerRun) begin
        if (sent % 24 == 0) begin
          base = $urandom_range(0, 127);
          span = ($urandom_range(0, 9) == 0) ? 128 : $urandom_range(2, 12);
        end
        random_request(base, span, counted);
        if (counted) sent++;
      end
    end
    start_i <= 1'b0;

    // Drain: wait for the last result, then watch for stray strobes before the verdict
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("midi_note_sustain_tracker_unit_tb: clean");
    end else begin
      $display("midi_note_sustain_tracker_unit_tb: errors");
    end
    $finish;
  end

endmodule

[sim.f]
sv/mnst_pkg.sv
sv/mnst_ctrl.sv
sv/mnst_datapath.sv
sv/midi_note_sustain_tracker_unit.sv
sv/mnst_checker.sv
verif/midi_note_sustain_tracker_checker.sv
verif/midi_note_sustain_tracker_unit_tb.sv
